/* rtl/core/triangle_barycentric_coordinates_core_assert.svh */
// ---------------------------------------------------------------------------
// barycentric core assertion macros
// implication checks on the core clock, held off during reset
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_COORDINATES_CORE_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_COORDINATES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TBC_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("tbc assertion failed");
// next-cycle implication
`define TBC_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("tbc assertion failed");
`else
`define TBC_ASSERT_IMPL(lbl, a, b)
`define TBC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

/* rtl/core/tbc_pkg.sv */
// ---------------------------------------------------------------------------
// tbc_pkg
// word types and fixed widths of the barycentric core
// ---------------------------------------------------------------------------
package tbc_pkg;
	localparam int COORD_W = 12;
	localparam int OUT_W   = 20;

	typedef struct packed {
		logic signed [COORD_W-1:0] corner_a_x;
		logic signed [COORD_W-1:0] corner_a_y;
		logic signed [COORD_W-1:0] corner_b_x;
		logic signed [COORD_W-1:0] corner_b_y;
		logic signed [COORD_W-1:0] corner_c_x;
		logic signed [COORD_W-1:0] corner_c_y;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} cmd_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] weight_u;
		logic signed [OUT_W-1:0] weight_v;
		logic signed [OUT_W-1:0] weight_w;
		logic                    degenerate;
		logic                    saturated;
	} rsp_word_t;
endpackage

/* rtl/core/triangle_barycentric_coordinates_core.sv */
// ---------------------------------------------------------------------------
// triangle_barycentric_coordinates_core
// barycentric weights of a point against a 2d triangle, fully pipelined
// ---------------------------------------------------------------------------
// usage
//   cmd channel: one word per triangle and query point (valid / stall)
//   rsp channel: one word per cmd word, in order: u, v, w, degenerate, saturated
//   pipeline stages, in order:
//     three arithmetic stages, one restoring-divider stage per quotient bit,
//     one sign / sum / clip stage that is also the output register
//   throughput: one word per cycle unless stalled; the quotient bit chain sets the depth
//   stall: the whole pipe freezes when the output word is held by rsp_stall,
//     and cmd_stall follows; bubbles travel down the pipe with the words
//   reset: all valid bits clear, payload registers keep whatever they held
//   degenerate triangle (zero cross product): weights 0, degenerate set
// ---------------------------------------------------------------------------
`include "triangle_barycentric_coordinates_core_assert.svh"

module triangle_barycentric_coordinates_core
	import tbc_pkg::*;
#(
	parameter int FRAC_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);
	// coordinate width is fixed by the word type
	localparam int COORD_BITS = COORD_W;

	// widths: difference, product / cross, magnitude, dividend, final sum
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int MW = PW - 1;
	localparam int NB = MW + FRAC_BITS;
	localparam int SW = NB + 3;

	localparam logic signed [SW-1:0] ONE_FX  = SW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] OUT_MAX = SW'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SW-1:0] OUT_MIN = -(SW'(1) <<< (OUT_W - 1));

	// pipe advances unless a finished word is held at the output
	logic adv;
	assign adv       = !rsp_valid || !rsp_stall;
	assign cmd_stall = !adv;

	// stage 1: sign-adjust inputs, edge and point vectors
	logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
	assign ax = COORD_BITS'(cmd_word.corner_a_x);
	assign ay = COORD_BITS'(cmd_word.corner_a_y);
	assign bx = COORD_BITS'(cmd_word.corner_b_x);
	assign by = COORD_BITS'(cmd_word.corner_b_y);
	assign cx = COORD_BITS'(cmd_word.corner_c_x);
	assign cy = COORD_BITS'(cmd_word.corner_c_y);
	assign px = COORD_BITS'(cmd_word.point_x);
	assign py = COORD_BITS'(cmd_word.point_y);

	logic                 vld_s1;
	logic signed [DW-1:0] e0x_s1, e0y_s1, e1x_s1, e1y_s1, e2x_s1, e2y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e0x_s1 <= DW'(bx) - DW'(ax);
			e0y_s1 <= DW'(by) - DW'(ay);
			e1x_s1 <= DW'(cx) - DW'(ax);
			e1y_s1 <= DW'(cy) - DW'(ay);
			e2x_s1 <= DW'(px) - DW'(ax);
			e2y_s1 <= DW'(py) - DW'(ay);
		end
	end

	// stage 2: the six products of the three cross products
	logic                 vld_s2;
	logic signed [PW-1:0] pd0_s2, pd1_s2, pu0_s2, pu1_s2, pv0_s2, pv1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pd0_s2 <= PW'(e0x_s1) * PW'(e1y_s1);
			pd1_s2 <= PW'(e0y_s1) * PW'(e1x_s1);
			pu0_s2 <= PW'(e2x_s1) * PW'(e1y_s1);
			pu1_s2 <= PW'(e2y_s1) * PW'(e1x_s1);
			pv0_s2 <= PW'(e0x_s1) * PW'(e2y_s1);
			pv1_s2 <= PW'(e0y_s1) * PW'(e2x_s1);
		end
	end

	// stage 3: cross products, split into sign and magnitude
	logic signed [PW-1:0] den, nu, nv;
	logic        [PW-1:0] den_abs, nu_abs, nv_abs;
	assign den     = pd0_s2 - pd1_s2;
	assign nu      = pu0_s2 - pu1_s2;
	assign nv      = pv0_s2 - pv1_s2;
	assign den_abs = den[PW-1] ? -den : den;
	assign nu_abs  = nu[PW-1] ? -nu : nu;
	assign nv_abs  = nv[PW-1] ? -nv : nv;

	// divider pipe, index 0 is stage 3, index NB holds the finished quotients
	logic          vld_s   [0:NB];
	logic          zero_s  [0:NB];
	logic          negu_s  [0:NB];
	logic          negv_s  [0:NB];
	logic [MW-1:0] md_s    [0:NB];
	logic [NB-1:0] nu_s    [0:NB];
	logic [NB-1:0] nv_s    [0:NB];
	logic [MW-1:0] ru_s    [0:NB];
	logic [MW-1:0] rv_s    [0:NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= (den == '0);
			negu_s[0] <= nu[PW-1] ^ den[PW-1];
			negv_s[0] <= nv[PW-1] ^ den[PW-1];
			md_s[0]   <= den_abs[MW-1:0];
			nu_s[0]   <= {nu_abs[MW-1:0], {FRAC_BITS{1'b0}}};
			nv_s[0]   <= {nv_abs[MW-1:0], {FRAC_BITS{1'b0}}};
			ru_s[0]   <= '0;
			rv_s[0]   <= '0;
		end
	end

	// one restoring step per stage: quotient bits shift in behind the dividend
	for (genvar k = 0; k < NB; k++) begin : g_div
		logic [MW:0] tu, tv;
		logic        geu, gev;
		assign tu  = {ru_s[k], nu_s[k][NB-1]};
		assign tv  = {rv_s[k], nv_s[k][NB-1]};
		assign geu = tu >= {1'b0, md_s[k]};
		assign gev = tv >= {1'b0, md_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[k+1] <= zero_s[k];
				negu_s[k+1] <= negu_s[k];
				negv_s[k+1] <= negv_s[k];
				md_s[k+1]   <= md_s[k];
				ru_s[k+1]   <= geu ? MW'(tu - {1'b0, md_s[k]}) : MW'(tu);
				rv_s[k+1]   <= gev ? MW'(tv - {1'b0, md_s[k]}) : MW'(tv);
				nu_s[k+1]   <= {nu_s[k][NB-2:0], geu};
				nv_s[k+1]   <= {nv_s[k][NB-2:0], gev};
			end
		end
	end

	// last stage: apply signs, form w, clip to the output range
	logic signed [SW-1:0] u_full, v_full, w_full;
	logic signed [OUT_W-1:0] u_clip, v_clip, w_clip;
	logic                 u_sat, v_sat, w_sat;

	always_comb begin
		u_full = negu_s[NB] ? -$signed({3'b000, nu_s[NB]}) : $signed({3'b000, nu_s[NB]});
		v_full = negv_s[NB] ? -$signed({3'b000, nv_s[NB]}) : $signed({3'b000, nv_s[NB]});
		w_full = ONE_FX - u_full - v_full;
		u_sat  = (u_full > OUT_MAX) || (u_full < OUT_MIN);
		v_sat  = (v_full > OUT_MAX) || (v_full < OUT_MIN);
		w_sat  = (w_full > OUT_MAX) || (w_full < OUT_MIN);
		u_clip = (u_full > OUT_MAX) ? OUT_W'(OUT_MAX) :
			(u_full < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(u_full);
		v_clip = (v_full > OUT_MAX) ? OUT_W'(OUT_MAX) :
			(v_full < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(v_full);
		w_clip = (w_full > OUT_MAX) ? OUT_W'(OUT_MAX) :
			(w_full < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(w_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s[NB]) begin
				rsp_word <= '{weight_u: '0, weight_v: '0, weight_w: '0,
					degenerate: 1'b1, saturated: 1'b0};
			end else begin
				rsp_word <= '{weight_u: u_clip, weight_v: v_clip, weight_w: w_clip,
					degenerate: 1'b0, saturated: u_sat || v_sat || w_sat};
			end
		end
	end

	// a degenerate word carries zero weights and no clip flag
	`TBC_ASSERT_IMPL(a_degen_zero, rsp_valid && rsp_word.degenerate,
		rsp_word.weight_u == '0 && rsp_word.weight_v == '0 && rsp_word.weight_w == '0)
	`TBC_ASSERT_IMPL(a_degen_nosat, rsp_valid && rsp_word.degenerate, !rsp_word.saturated)
	// an empty output slot never holds off the input
	`TBC_ASSERT_IMPL(a_no_false_stall, !rsp_valid, !cmd_stall)
	// an accepted word enters the first stage
	`TBC_ASSERT_NEXT(a_enter, cmd_valid && !cmd_stall, vld_s1)
endmodule

/* tb/sv/triangle_barycentric_coordinates_core_checker.sv */
// ---------------------------------------------------------------------------
// triangle_barycentric_coordinates_core_checker
// watches both channels, predicts the weights of each accepted cmd word
// and compares every rsp word against the oldest prediction
// ---------------------------------------------------------------------------
module triangle_barycentric_coordinates_core_checker
	import tbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_stall,
	input  cmd_word_t cmd_word,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp_word,
	output int        fail_count,
	output int        pending
);
	localparam int FRAC = 16;
	localparam longint WMAX = (64'sd1 <<< (OUT_W - 1)) - 1;
	localparam longint WMIN = -(64'sd1 <<< (OUT_W - 1));

	rsp_word_t weights_q[$];

	function automatic longint fixed_ratio(longint num, longint den);
		longint mn, md, q;
		mn = (num < 0) ? -num : num;
		md = (den < 0) ? -den : den;
		q = (mn <<< FRAC) / md;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic logic [OUT_W-1:0] clip_weight(longint x, ref logic sat);
		if (x > WMAX) begin
			sat = 1'b1;
			x = WMAX;
		end
		if (x < WMIN) begin
			sat = 1'b1;
			x = WMIN;
		end
		return x[OUT_W-1:0];
	endfunction

	function automatic rsp_word_t barycentric_weights(cmd_word_t c);
		longint e0x, e0y, e1x, e1y, e2x, e2y, den, nu, nv, u, v, w;
		logic sat;
		rsp_word_t r;
		e0x = longint'(c.corner_b_x) - longint'(c.corner_a_x);
		e0y = longint'(c.corner_b_y) - longint'(c.corner_a_y);
		e1x = longint'(c.corner_c_x) - longint'(c.corner_a_x);
		e1y = longint'(c.corner_c_y) - longint'(c.corner_a_y);
		e2x = longint'(c.point_x) - longint'(c.corner_a_x);
		e2y = longint'(c.point_y) - longint'(c.corner_a_y);
		den = e0x * e1y - e0y * e1x;
		nu = e2x * e1y - e2y * e1x;
		nv = e0x * e2y - e0y * e2x;
		r = '0;
		if (den == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		sat = 1'b0;
		u = fixed_ratio(nu, den);
		v = fixed_ratio(nv, den);
		w = (64'sd1 <<< FRAC) - u - v;
		r.weight_u = clip_weight(u, sat);
		r.weight_v = clip_weight(v, sat);
		r.weight_w = clip_weight(w, sat);
		r.saturated = sat;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e;
		if (!arst_n) begin
			fail_count = 0;
			weights_q.delete();
		end else begin
			if (cmd_valid && !cmd_stall)
				weights_q.push_back(barycentric_weights(cmd_word));
			if (rsp_valid && !rsp_stall) begin
				if (weights_q.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					e = weights_q.pop_front();
					if (rsp_word.weight_u !== e.weight_u)
						report_mismatch("weight_u", rsp_word.weight_u, e.weight_u);
					if (rsp_word.weight_v !== e.weight_v)
						report_mismatch("weight_v", rsp_word.weight_v, e.weight_v);
					if (rsp_word.weight_w !== e.weight_w)
						report_mismatch("weight_w", rsp_word.weight_w, e.weight_w);
					if (rsp_word.degenerate !== e.degenerate)
						report_mismatch("degenerate", rsp_word.degenerate, e.degenerate);
					if (rsp_word.saturated !== e.saturated)
						report_mismatch("saturated", rsp_word.saturated, e.saturated);
				end
			end
		end
		pending = weights_q.size();
	end
endmodule

/* tb/sv/triangle_barycentric_coordinates_core_tb.sv */
// ---------------------------------------------------------------------------
// triangle_barycentric_coordinates_core_tb
// directed corner cases then random triangles, with random idling on both
// channels, one long rsp hold-off and two full drains; verdict from checker
// ---------------------------------------------------------------------------
module triangle_barycentric_coordinates_core_tb;
	import tbc_pkg::*;

	localparam int LATENCY   = 45;
	localparam int N_RANDOM  = 1500;
	localparam int MAX_CYCLE = 200000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd_word;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp_word;
	int        fail_count;
	int        pending;
	int        cycle;
	// rsp side idling: 0 random, 1 never stall, 2 long hold-off
	int        rsp_mode;
	logic      quiet;

	triangle_barycentric_coordinates_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
	);

	triangle_barycentric_coordinates_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timeout watchdog
	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > MAX_CYCLE) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// receiver stall, own process; long hold-off is counted here
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_mode == 2) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				rsp_stall <= 1'b0;
				rsp_mode = 0;
			end else if (rsp_mode == 1 || quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 16);
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] rnd_coord();
		case ($urandom_range(7))
			0: return {1'b1, {(COORD_W-1){1'b0}}};
			1: return {1'b0, {(COORD_W-1){1'b1}}};
			2: return COORD_W'($urandom_range(15) - 8);
			3, 4: return COORD_W'($urandom_range(255) - 128);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic cmd_word_t rnd_triangle();
		cmd_word_t c;
		int k;
		c = '0;
		c.corner_a_x = rnd_coord(); c.corner_a_y = rnd_coord();
		c.corner_b_x = rnd_coord(); c.corner_b_y = rnd_coord();
		c.corner_c_x = rnd_coord(); c.corner_c_y = rnd_coord();
		c.point_x = rnd_coord(); c.point_y = rnd_coord();
		k = $urandom_range(9);
		// coincident or collinear corners now and then
		if (k == 0) begin
			c.corner_b_x = c.corner_a_x; c.corner_b_y = c.corner_a_y;
		end else if (k == 1) begin
			c.corner_b_x = c.corner_a_x + COORD_W'(3);
			c.corner_b_y = c.corner_a_y + COORD_W'(5);
			c.corner_c_x = c.corner_a_x - COORD_W'(6);
			c.corner_c_y = c.corner_a_y - COORD_W'(10);
		end else if (k == 2) begin
			// point at a corner
			c.point_x = c.corner_c_x; c.point_y = c.corner_c_y;
		end
		return c;
	endfunction

	// one word, held until accepted; optional random idle before it
	task automatic send_word(cmd_word_t c, bit idle);
		if (idle) begin
			while ($urandom_range(99) < 16) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd_word  <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic send_tri(int ax, int ay, int bx, int by, int cx, int cy,
	                        int px, int py);
		cmd_word_t c;
		c.corner_a_x = COORD_W'(ax); c.corner_a_y = COORD_W'(ay);
		c.corner_b_x = COORD_W'(bx); c.corner_b_y = COORD_W'(by);
		c.corner_c_x = COORD_W'(cx); c.corner_c_y = COORD_W'(cy);
		c.point_x = COORD_W'(px); c.point_y = COORD_W'(py);
		send_word(c, 1'b1);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		cmd_word_t c;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_word  = '0;
		rsp_mode  = 0;
		quiet     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unit triangle, point at each corner and centroid-ish
		send_tri(0, 0, 1, 0, 0, 1, 0, 0);
		send_tri(0, 0, 1, 0, 0, 1, 1, 0);
		send_tri(0, 0, 1, 0, 0, 1, 0, 1);
		send_tri(0, 0, 3, 0, 0, 3, 1, 1);
		// negative-oriented triangle and fractional weights
		send_tri(0, 0, 0, 7, 7, 0, 2, 3);
		// degenerate: coincident corners, collinear corners, all zero
		send_tri(5, 5, 5, 5, 9, -3, 1, 1);
		send_tri(0, 0, 10, 10, -20, -20, 4, 4);
		send_tri(0, 0, 0, 0, 0, 0, 0, 0);
		// saturation: tiny triangle, far point, both signs
		send_tri(0, 0, 1, 0, 0, 1, 2047, 2047);
		send_tri(0, 0, 1, 0, 0, 1, -2048, -2048);
		send_tri(0, 0, 1, 0, 0, 1, 2047, -2048);
		// full-range extremes of every field
		send_tri(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047);
		send_tri(2047, 2047, -2048, 2047, 2047, -2048, -2048, -2048);
		send_tri(-2048, 2047, 2047, 2047, 0, -2048, 0, 0);
		send_tri(-1, -1, 2047, -2048, -2048, 2047, -1, 0);
		// point on an edge with exact halves, point outside but in range
		send_tri(0, 0, 2, 0, 0, 2, 1, 1);
		send_tri(0, 0, 4, 0, 0, 4, -4, 8);

		// drain pause with sender idle
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300) begin
				// long receiver hold-off while the sender keeps offering
				rsp_mode = 2;
			end
			if (i == 700) wait_drained();
			quiet = (i >= 900 && i < 1100);
			c = rnd_triangle();
			send_word(c, !quiet);
		end
		cmd_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
